// ===== hdl/lfpl_pkg.sv =====
// Shared constants and types for the LED frame power limiter.
// No dependencies; every other file in hdl/ uses this package.
package lfpl_pkg;

    localparam int MAX_BYTES         = 18;
    localparam int BITMAP_BYTES_DEF  = 18;
    localparam int BYTE_W            = 8;
    localparam int CNT_W             = 4;    // popcount of one byte, 0..8
    localparam int LIT_W             = 8;    // lit pixels, 0..144
    localparam int CSUM_W            = 10;   // r+g+b, 0..765
    localparam int MULT_W            = LIT_W + CSUM_W;
    localparam int POWER_W           = 17;
    localparam int COLOR_W           = 8;
    localparam int QUO_W             = COLOR_W;
    localparam int DVD_W             = COLOR_W + POWER_W;
    localparam int NCH               = 3;
    localparam int LOW_W             = 64;
    localparam int MID_W             = 64;
    localparam int HIGH_W            = 16;
    localparam int BITS_W            = LOW_W + MID_W + HIGH_W;

    localparam logic [POWER_W-1:0] POWER_LIMIT_RST = 17'h1FFFF;

    typedef logic [NCH-1:0][COLOR_W-1:0] color_t;

    // One divider stage worth of payload, three channels side by side.
    typedef struct packed {
        logic [NCH-1:0][POWER_W-1:0] rem;
        logic [NCH-1:0][DVD_W-1:0]   dvd;
        logic [NCH-1:0][QUO_W-1:0]   quo;
        color_t                      color;
        logic [POWER_W-1:0]          power;
        logic                        limited;
    } div_t;

endpackage

// ===== hdl/lfpl_ifs.sv =====
// Valid/ready channel interfaces for frames in and results out.
// Depends on lfpl_pkg for field widths.
interface lfpl_in_if;
    logic                              valid;
    logic                              ready;
    logic [lfpl_pkg::LOW_W-1:0]        bitmap_low;
    logic [lfpl_pkg::MID_W-1:0]        bitmap_mid;
    logic [lfpl_pkg::HIGH_W-1:0]       bitmap_high;
    logic [lfpl_pkg::COLOR_W-1:0]      red_in;
    logic [lfpl_pkg::COLOR_W-1:0]      green_in;
    logic [lfpl_pkg::COLOR_W-1:0]      blue_in;

    modport source (output valid, bitmap_low, bitmap_mid, bitmap_high,
                    red_in, green_in, blue_in, input ready);
    modport sink   (input valid, bitmap_low, bitmap_mid, bitmap_high,
                    red_in, green_in, blue_in, output ready);
endinterface

interface lfpl_out_if;
    logic                              valid;
    logic                              ready;
    logic [lfpl_pkg::COLOR_W-1:0]      red_out;
    logic [lfpl_pkg::COLOR_W-1:0]      green_out;
    logic [lfpl_pkg::COLOR_W-1:0]      blue_out;
    logic                              was_limited;
    logic [lfpl_pkg::POWER_W-1:0]      measured_power;

    modport source (output valid, red_out, green_out, blue_out, was_limited,
                    measured_power, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, was_limited,
                    measured_power, output ready);
endinterface

// ===== hdl/lfpl_lane.sv =====
// One bitmap lane: registered popcount of a single bitmap byte.
// Depends on lfpl_pkg.
module lfpl_lane #(
    parameter bit USED = 1'b1
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [lfpl_pkg::BYTE_W-1:0]   byte_in,
    output logic [lfpl_pkg::CNT_W-1:0]    count_reg
);
    import lfpl_pkg::*;

    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            count_next = count_next + CNT_W'(byte_in[i]);
        end
        if (!USED)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/lfpl_merge.sv =====
// Merge stage: adds the per-lane byte counts into the lit pixel count.
// Depends on lfpl_pkg.
module lfpl_merge (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [lfpl_pkg::MAX_BYTES-1:0][lfpl_pkg::CNT_W-1:0] counts,
    output logic [lfpl_pkg::LIT_W-1:0]                    lit_reg
);
    import lfpl_pkg::*;

    localparam int GRP    = 3;
    localparam int PER    = (MAX_BYTES + GRP - 1) / GRP;

    logic [GRP-1:0][LIT_W-1:0] part;
    logic [LIT_W-1:0]          lit_next;

    // Three short chains, then a final three-way add.
    always_comb
    begin
        for (int g = 0; g < GRP; g++)
        begin
            part[g] = '0;
            for (int j = 0; j < PER; j++)
            begin
                if (g * PER + j < MAX_BYTES)
                begin
                    part[g] = part[g] + LIT_W'(counts[g * PER + j]);
                end
            end
        end
        lit_next = '0;
        for (int g = 0; g < GRP; g++)
        begin
            lit_next = lit_next + part[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lit_reg <= lit_next;
        end
    end

endmodule

// ===== hdl/lfpl_div_step.sv =====
// One restoring-division step for all three color channels.
// Depends on lfpl_pkg (div_t); chained eight deep in the top level.
module lfpl_div_step #(
    parameter int STEP = 7
) (
    input  logic           clk,
    input  logic           en,
    input  lfpl_pkg::div_t d_in,
    output lfpl_pkg::div_t d_reg
);
    import lfpl_pkg::*;

    localparam int BIT_W = $clog2(DVD_W);

    div_t                  d_next;
    logic [POWER_W:0]      trial;
    logic [POWER_W:0]      divisor;

    always_comb
    begin
        d_next  = d_in;
        divisor = {1'b0, d_in.power};
        trial   = '0;
        for (int c = 0; c < NCH; c++)
        begin
            trial = {d_in.rem[c], d_in.dvd[c][BIT_W'(STEP)]};
            if (trial >= divisor)
            begin
                d_next.rem[c] = POWER_W'(trial - divisor);
                d_next.quo[c] = {d_in.quo[c][QUO_W-2:0], 1'b1};
            end
            else
            begin
                d_next.rem[c] = trial[POWER_W-1:0];
                d_next.quo[c] = {d_in.quo[c][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

endmodule

// ===== hdl/led_frame_power_limiter_top.sv =====
// Top level of the LED frame power limiter: lanes, merge, multiply, divider, output.
// Depends on lfpl_pkg, lfpl_ifs, lfpl_lane, lfpl_merge, lfpl_div_step.
//
// Use:
//   frame_in carries one frame per transfer: a 144-bit on/off bitmap split in
//   three fields and an RGB color. result_out carries one result per frame, in
//   order: the limited color, a was_limited flag and the measured power
//   (lit pixels times r+g+b). The user must write power_limit through
//   cfg_wr_en / cfg_wr_data only while no frame is in flight; the block does
//   not enforce this. Throughput is one frame per cycle while result_out is
//   not stalled. Frames pass through byte popcount lanes, one merge, one
//   multiply, eight one-bit divider stages and the output register.
//   Each stage holds its own valid bit, so empty stages fill while the
//   receiver stalls; frame_in.ready drops only once every stage is full.
//   Reset clears all valid bits and sets power_limit to 131071.
module led_frame_power_limiter_top #(
    parameter int BITMAP_BYTES = lfpl_pkg::BITMAP_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lfpl_pkg::POWER_W-1:0]   cfg_wr_data,
    lfpl_in_if.sink                        frame_in,
    lfpl_out_if.source                     result_out
);
    import lfpl_pkg::*;

    localparam int NB     = (BITMAP_BYTES > MAX_BYTES) ? MAX_BYTES : BITMAP_BYTES;
    localparam int S_DIV  = 3;
    localparam int S_OUT  = S_DIV + QUO_W;
    localparam int NSTG   = S_OUT + 1;

    logic [POWER_W-1:0]                limit_reg;
    logic [NSTG-1:0]                   vld_reg;
    logic [NSTG-1:0]                   vld_next;
    logic [NSTG:0]                     rdy;

    logic [BITS_W-1:0]                 bits;
    logic [MAX_BYTES-1:0][CNT_W-1:0]   counts;
    logic [LIT_W-1:0]                  lit_reg;

    color_t                            col0_reg;
    color_t                            col1_reg;
    color_t                            col2_reg;
    logic [CSUM_W-1:0]                 csum1_reg;
    logic [MULT_W-1:0]                 mult_full;
    logic [POWER_W-1:0]                power2_reg;
    logic [NCH-1:0][DVD_W-1:0]         prod2_reg;

    div_t                              dchain [0:QUO_W];

    color_t                            col_out_reg;
    logic                              lim_out_reg;
    logic [POWER_W-1:0]                pwr_out_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= POWER_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // ---------------- pipeline control ----------------
    // A stage loads when it is empty or the stage after it moves on.
    always_comb
    begin
        rdy[NSTG] = result_out.ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k + 1];
        end
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = frame_in.valid;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign frame_in.ready = rdy[0];

    // ---------------- stage 0: byte lanes ----------------
    assign bits = {frame_in.bitmap_high, frame_in.bitmap_mid, frame_in.bitmap_low};

    for (genvar b = 0; b < MAX_BYTES; b++)
    begin : g_lane
        lfpl_lane #(
            .USED (b < NB)
        ) u_lane (
            .clk       (clk),
            .en        (rdy[0]),
            .byte_in   (bits[b * BYTE_W +: BYTE_W]),
            .count_reg (counts[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            col0_reg <= {frame_in.blue_in, frame_in.green_in, frame_in.red_in};
        end
    end

    // ---------------- stage 1: merge ----------------
    lfpl_merge u_merge (
        .clk     (clk),
        .en      (rdy[1]),
        .counts  (counts),
        .lit_reg (lit_reg)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            col1_reg  <= col0_reg;
            csum1_reg <= CSUM_W'(col0_reg[0]) + CSUM_W'(col0_reg[1])
                         + CSUM_W'(col0_reg[2]);
        end
    end

    // ---------------- stage 2: power and dividends ----------------
    assign mult_full = MULT_W'(lit_reg) * MULT_W'(csum1_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            col2_reg   <= col1_reg;
            power2_reg <= mult_full[POWER_W-1:0];
            for (int c = 0; c < NCH; c++)
            begin
                prod2_reg[c] <= DVD_W'(col1_reg[c]) * DVD_W'(limit_reg);
            end
        end
    end

    // Quotient is at most the channel value when power >= limit, so the
    // top bits of the dividend are already below the divisor.
    always_comb
    begin
        dchain[0].power   = power2_reg;
        dchain[0].limited = (power2_reg != '0) && (power2_reg >= limit_reg);
        dchain[0].color   = col2_reg;
        for (int c = 0; c < NCH; c++)
        begin
            dchain[0].dvd[c] = prod2_reg[c];
            dchain[0].rem[c] = prod2_reg[c][DVD_W-1:QUO_W];
            dchain[0].quo[c] = '0;
        end
    end

    // ---------------- stages 3..10: divider ----------------
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        lfpl_div_step #(
            .STEP (QUO_W - 1 - k)
        ) u_step (
            .clk   (clk),
            .en    (rdy[S_DIV + k]),
            .d_in  (dchain[k]),
            .d_reg (dchain[k + 1])
        );
    end

    // ---------------- stage 11: output register ----------------
    always_ff @(posedge clk)
    begin
        if (rdy[S_OUT])
        begin
            lim_out_reg <= dchain[QUO_W].limited;
            pwr_out_reg <= dchain[QUO_W].power;
            for (int c = 0; c < NCH; c++)
            begin
                col_out_reg[c] <= dchain[QUO_W].limited ? dchain[QUO_W].quo[c]
                                                        : dchain[QUO_W].color[c];
            end
        end
    end

    assign result_out.valid          = vld_reg[S_OUT];
    assign result_out.red_out        = col_out_reg[0];
    assign result_out.green_out      = col_out_reg[1];
    assign result_out.blue_out       = col_out_reg[2];
    assign result_out.was_limited    = lim_out_reg;
    assign result_out.measured_power = pwr_out_reg;

endmodule
